// ===== hw/rtl/mvp_pkg.sv =====
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared constants, result type and X.25 CRC step for the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mvp_pkg;

    // Parser phase codes
    localparam logic [1:0] PH_SYNC   = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    // Request and result kinds
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_TABLE = 1'b1;
    localparam logic RES_PAYLOAD   = 1'b0;
    localparam logic RES_FRAME_END = 1'b1;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFE;
    localparam logic [9:0]  FRAME_OVERHEAD = 10'd8;
    localparam logic [8:0]  PAYLOAD_START  = 9'd6;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;

    // Header byte positions inside a frame
    localparam logic [8:0] POS_SEQ  = 9'd2;
    localparam logic [8:0] POS_SYS  = 9'd3;
    localparam logic [8:0] POS_COMP = 9'd4;
    localparam logic [8:0] POS_MSG  = 9'd5;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic [7:0]  pidx;
        logic [7:0]  len;
        logic [7:0]  seq;
        logic [7:0]  sys;
        logic [7:0]  comp;
        logic [7:0]  msg;
        logic        ok;
        logic [31:0] good;
        logic [31:0] bad;
    } t_result;

    // One byte of the X.25 (CRC-16/MCRF4XX) update
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] t;
        t = data ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mvp_ram.sv =====
// ----------------------------------------------------------------------------
// mvp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mavlink_v1_frame_parser.sv =====
// ----------------------------------------------------------------------------
// mavlink_v1_frame_parser
// Frame parser for v1 telemetry frames with X.25 CRC and CRC-extra lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per item. tuser = 0 carries a received serial byte,
//   tuser = 1 writes the CRC-extra byte of one message id into the table.
//   Master channel: one word per payload byte (tuser = 0) and one word per
//   frame end (tuser = 1) with header, crc_ok flag and good/bad frame counts.
//   Throughput: one input word per cycle while the receiver keeps up; every
//   word is handled in the cycle it is accepted (single-byte CRC update).
//   Latency: a result is valid in the cycle after the word that caused it.
//   The CRC-extra table lives in a 256x8 RAM read continuously at the current
//   message id; a write to that id in the previous cycle is forwarded.
//   Stall: a single output register holds the pending result; input is taken
//   whenever that register is empty or being drained this cycle, so a stalled
//   receiver stalls the input once a result is pending.
//   Reset (synchronous, active low): parser hunts for sync, counts clear, and
//   all table entries read as zero until written (per-entry valid bits).
// ----------------------------------------------------------------------------
`default_nettype none

module mavlink_v1_frame_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave side
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [15:8] table_index, [23:16] table_value
    input  wire [23:0]  s_axis_tdata,
    // [0] req_type
    input  wire [0:0]   s_axis_tuser,
    // Master side
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_length,
    // [31:24] frame_seq, [39:32] sys_id, [47:40] comp_id, [55:48] msg_id,
    // [56] crc_ok, [88:57] good_count, [120:89] bad_count, [127:121] zero
    output logic [127:0] m_axis_tdata,
    // [0] result_kind
    output logic [0:0]  m_axis_tuser
);

    localparam int CntOutW = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

    // Input decode
    logic       in_acc;
    logic       is_wr;
    logic       is_byte;
    logic [7:0] in_byte;
    logic [7:0] wr_idx;
    logic [7:0] wr_val;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign is_wr   = in_acc && (s_axis_tuser[0] == mvp_pkg::REQ_TABLE);
    assign is_byte = in_acc && (s_axis_tuser[0] == mvp_pkg::REQ_BYTE);
    assign in_byte = s_axis_tdata[7:0];
    assign wr_idx  = s_axis_tdata[15:8];
    assign wr_val  = s_axis_tdata[23:16];

    // Parser state
    logic [1:0]             r_phase, n_phase;
    logic [8:0]             r_pos, n_pos;
    logic [7:0]             r_len, n_len;
    logic [7:0]             r_seq, n_seq;
    logic [7:0]             r_sys, n_sys;
    logic [7:0]             r_comp, n_comp;
    logic [7:0]             r_msg, n_msg;
    logic [15:0]            r_crc, n_crc;
    logic [7:0]             r_chk_low, n_chk_low;
    logic [COUNT_WIDTH-1:0] r_good, n_good;
    logic [COUNT_WIDTH-1:0] r_bad, n_bad;

    // CRC-extra table: RAM plus valid bits and write forwarding
    logic [255:0] r_ext_vld;
    logic         r_rd_vld;
    logic         r_fwd_hit;
    logic [7:0]   r_fwd_data;
    logic [7:0]   ram_rdata;
    logic [7:0]   extra;

    mvp_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_extra_ram (
        .i_clk   (i_clk),
        .i_we    (is_wr),
        .i_waddr (wr_idx),
        .i_wdata (wr_val),
        .i_raddr (r_msg),
        .o_rdata (ram_rdata)
    );

    assign extra = r_fwd_hit ? r_fwd_data : (r_rd_vld ? ram_rdata : 8'h00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (is_wr) begin
                r_ext_vld[wr_idx] <= 1'b1;
            end
            r_rd_vld  <= r_ext_vld[r_msg];
            // The message id never changes on a table write, so the compare
            // against the current read address is exact.
            r_fwd_hit <= is_wr && (wr_idx == r_msg);
        end
        r_fwd_data <= wr_val;
    end

    // Frame parsing
    logic              load;
    mvp_pkg::t_result  res;
    logic [8:0]        pay_end;
    logic              in_pay;
    logic [15:0]       fin_crc;
    logic              crc_match;
    logic [9:0]        pos_next;
    logic [9:0]        total;

    assign pay_end   = mvp_pkg::PAYLOAD_START + {1'b0, r_len};
    assign in_pay    = r_pos < pay_end;
    assign fin_crc   = mvp_pkg::crc_step(r_crc, extra);
    assign crc_match = fin_crc == {in_byte, r_chk_low};
    assign pos_next  = {1'b0, r_pos} + 10'd1;
    assign total     = {2'b00, r_len} + mvp_pkg::FRAME_OVERHEAD;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len     = r_len;
        n_seq     = r_seq;
        n_sys     = r_sys;
        n_comp    = r_comp;
        n_msg     = r_msg;
        n_crc     = r_crc;
        n_chk_low = r_chk_low;
        n_good    = r_good;
        n_bad     = r_bad;
        load      = 1'b0;
        res.kind  = mvp_pkg::RES_PAYLOAD;
        res.pbyte = 8'h00;
        res.pidx  = 8'h00;
        res.ok    = 1'b0;
        if (is_byte) begin
            case (r_phase)
                mvp_pkg::PH_SYNC: begin
                    if (in_byte == mvp_pkg::SYNC_BYTE) begin
                        n_phase = mvp_pkg::PH_LENGTH;
                    end
                end
                mvp_pkg::PH_LENGTH: begin
                    // A 0xFE here is a length, not a fresh sync
                    n_len   = in_byte;
                    n_crc   = mvp_pkg::crc_step(mvp_pkg::CRC_INIT, in_byte);
                    n_pos   = mvp_pkg::POS_SEQ;
                    n_phase = mvp_pkg::PH_BODY;
                end
                mvp_pkg::PH_BODY: begin
                    if (in_pay) begin
                        n_crc = mvp_pkg::crc_step(r_crc, in_byte);
                    end
                    if (r_pos == mvp_pkg::POS_SEQ) begin
                        n_seq = in_byte;
                    end else if (r_pos == mvp_pkg::POS_SYS) begin
                        n_sys = in_byte;
                    end else if (r_pos == mvp_pkg::POS_COMP) begin
                        n_comp = in_byte;
                    end else if (r_pos == mvp_pkg::POS_MSG) begin
                        n_msg = in_byte;
                    end else if (in_pay) begin
                        load      = 1'b1;
                        res.pbyte = in_byte;
                        res.pidx  = 8'(r_pos - mvp_pkg::PAYLOAD_START);
                    end else if (r_pos == pay_end) begin
                        n_chk_low = in_byte;
                    end else begin
                        // Last byte: fold in CRC-extra and judge the frame
                        load     = 1'b1;
                        res.kind = mvp_pkg::RES_FRAME_END;
                        res.ok   = crc_match;
                        if (crc_match) begin
                            n_good = r_good + COUNT_WIDTH'(1);
                        end else begin
                            n_bad = r_bad + COUNT_WIDTH'(1);
                        end
                    end
                    n_pos = pos_next[8:0];
                    if (pos_next >= total) begin
                        n_phase = mvp_pkg::PH_SYNC;
                        n_pos   = 9'd0;
                    end
                end
                default: begin
                    n_phase = mvp_pkg::PH_SYNC;
                end
            endcase
        end
        res.len  = r_len;
        res.seq  = r_seq;
        res.sys  = r_sys;
        res.comp = r_comp;
        res.msg  = r_msg;
        res.good = 32'(n_good[CntOutW-1:0]);
        res.bad  = 32'(n_bad[CntOutW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mvp_pkg::PH_SYNC;
            r_pos     <= '0;
            r_len     <= '0;
            r_seq     <= '0;
            r_sys     <= '0;
            r_comp    <= '0;
            r_msg     <= '0;
            r_crc     <= mvp_pkg::CRC_INIT;
            r_chk_low <= '0;
            r_good    <= '0;
            r_bad     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_seq     <= n_seq;
            r_sys     <= n_sys;
            r_comp    <= n_comp;
            r_msg     <= n_msg;
            r_crc     <= n_crc;
            r_chk_low <= n_chk_low;
            r_good    <= n_good;
            r_bad     <= n_bad;
        end
    end

    // Output register: load a new result, or drop the valid once taken
    mvp_pkg::t_result r_out;
    logic             r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tuser[0] = r_out.kind;
    assign m_axis_tdata    = {7'b0000000, r_out.bad, r_out.good, r_out.ok, r_out.msg,
                              r_out.comp, r_out.sys, r_out.seq, r_out.len,
                              r_out.pidx, r_out.pbyte};

    // Assertions
    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mvp_pkg::PH_BODY) |-> (r_pos >= mvp_pkg::POS_SEQ) &&
                                          ({1'b0, r_pos} < total))
        else $error("body position out of frame range");

    a_sync_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mvp_pkg::PH_SYNC) |-> (r_pos == 9'd0))
        else $error("position not cleared while hunting for sync");

    a_end_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && res.kind == mvp_pkg::RES_FRAME_END) |=>
            ((r_good != $past(r_good)) != (r_bad != $past(r_bad))))
        else $error("frame end did not bump exactly one counter");

    a_pidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == mvp_pkg::RES_PAYLOAD) |-> (r_out.pidx < r_out.len))
        else $error("payload index beyond frame length");

endmodule

`default_nettype wire
